FILE: design/spsq_pkg.sv
package spsq_pkg;

   typedef enum logic [1:0] {
      KIND_PUSH = 2'd0,
      KIND_POP  = 2'd1,
      KIND_ENQ  = 2'd2,
      KIND_DEQ  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LINK,
      ST_HEAD
   } state_type;

   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [23:0] price;
      logic [15:0] qty;
      logic [15:0] id;
   } rec_type;

endpackage

FILE: design/spsq_next_ram.sv
module spsq_next_ram #(
   parameter int POOL_SIZE = 16,
   parameter int IW = $clog2(POOL_SIZE)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          rd_en,
   input  logic [IW-1:0] rd_idx,
   output logic [IW:0]   rd_next,
   input  logic          wr_en,
   input  logic [IW-1:0] wr_idx,
   input  logic [IW:0]   wr_ptr,
   input  logic          claim_en,
   input  logic [IW-1:0] claim_idx
);

   logic [IW:0]   mem [POOL_SIZE];
   logic [IW:0]   q_ff;
   logic [IW-1:0] idx_ff;
   logic          fresh_ff;
   logic [IW:0]   hw_ff;
   logic [IW:0]   hw_in;

   // nodes at or above the fill count still hold their reset link
   always_comb begin
      hw_in = hw_ff;
      if (claim_en && ({1'b0, claim_idx} == hw_ff)) begin
         hw_in = hw_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hw_ff <= '0;
      end else begin
         hw_ff <= hw_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_ptr;
      end
      if (rd_en) begin
         q_ff     <= mem[rd_idx];
         idx_ff   <= rd_idx;
         fresh_ff <= ({1'b0, rd_idx} >= hw_ff);
      end
   end

   assign rd_next = fresh_ff ? ({1'b0, idx_ff} + 1'b1) : q_ff;

endmodule

FILE: design/spsq_rec_ram.sv
module spsq_rec_ram #(
   parameter int POOL_SIZE = 16,
   parameter int IW = $clog2(POOL_SIZE)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IW-1:0]    wr_idx,
   input  spsq_pkg::rec_type wr_data,
   input  logic             rd_en,
   input  logic [IW-1:0]    rd_idx,
   output spsq_pkg::rec_type rd_data
);
   import spsq_pkg::*;

   rec_type mem [POOL_SIZE];
   rec_type q_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         q_ff <= mem[rd_idx];
      end
   end

   assign rd_data = q_ff;

endmodule

FILE: design/shared_pool_stack_queue_top.sv
// channel | direction | handshake          | payload
// req     | in        | req_valid/req_stall | kind, product record
// rsp     | out       | rsp_valid/rsp_stall | status flags, head record
//
// After the accepting edge, which starts the link read, a word passes through
// link update (pointer and link writes, record read), then head select, which raises rsp_valid.
// A new word is accepted only in idle or in head select, since the link memory read
// must return before the pointers and links can be written.
// Reset is synchronous and holds req_stall high; the link memory uses a fill count.
// A stalled result holds the block in head select until rsp_stall drops.
module shared_pool_stack_queue_top #(
   parameter int POOL_SIZE = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [15:0] req_prod_id,
   input  logic [15:0] req_quantity,
   input  logic [23:0] req_price_cents,
   input  logic [4:0]  req_exp_day,
   input  logic [3:0]  req_exp_month,
   input  logic [13:0] req_exp_year,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_ok,
   output logic        rsp_stack_empty,
   output logic        rsp_queue_empty,
   output logic        rsp_pool_full,
   output logic        rsp_head_valid,
   output logic [15:0] rsp_head_id,
   output logic [15:0] rsp_head_qty,
   output logic [23:0] rsp_head_price,
   output logic [4:0]  rsp_head_day,
   output logic [3:0]  rsp_head_month,
   output logic [13:0] rsp_head_year
);
   import spsq_pkg::*;

   localparam int          IW  = $clog2(POOL_SIZE);
   localparam logic [IW:0] NIL = (IW + 1)'(POOL_SIZE);

   state_type   state_ff, state_in;
   kind_type    kind_ff, kind_in;
   rec_type     rec_ff, rec_in;
   logic [IW:0] free_head_ff, free_head_in;
   logic [IW:0] stack_top_ff, stack_top_in;
   logic [IW:0] queue_head_ff, queue_head_in;
   logic [IW:0] queue_tail_ff, queue_tail_in;
   logic        ok_ff, ok_in;
   logic        hlive_ff, hlive_in;
   logic        fwd_ff, fwd_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_ok_ff, rsp_ok_in;
   logic        rsp_se_ff, rsp_se_in;
   logic        rsp_qe_ff, rsp_qe_in;
   logic        rsp_pf_ff, rsp_pf_in;
   logic        rsp_hv_ff, rsp_hv_in;
   rec_type     rsp_rec_ff, rsp_rec_in;

   logic          accept;
   logic          out_free;
   logic [IW:0]   rd_ptr;
   logic          lk_rd_en;
   logic [IW-1:0] lk_rd_idx;
   logic [IW:0]   lk_next;
   logic          lk_wr_en;
   logic [IW-1:0] lk_wr_idx;
   logic [IW:0]   lk_wr_ptr;
   logic          take;
   logic [IW:0]   head_ptr;
   logic          rec_rd_en;
   logic [IW-1:0] rec_rd_idx;
   rec_type       rec_q;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = reset ||
                      !((state_ff == ST_IDLE) || ((state_ff == ST_HEAD) && out_free));
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      rec_in        = rec_ff;
      free_head_in  = free_head_ff;
      stack_top_in  = stack_top_ff;
      queue_head_in = queue_head_ff;
      queue_tail_in = queue_tail_ff;
      ok_in         = ok_ff;
      hlive_in      = hlive_ff;
      fwd_in        = fwd_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_ok_in     = rsp_ok_ff;
      rsp_se_in     = rsp_se_ff;
      rsp_qe_in     = rsp_qe_ff;
      rsp_pf_in     = rsp_pf_ff;
      rsp_hv_in     = rsp_hv_ff;
      rsp_rec_in    = rsp_rec_ff;
      rd_ptr        = free_head_ff;
      lk_rd_en      = 1'b0;
      lk_wr_en      = 1'b0;
      lk_wr_idx     = '0;
      lk_wr_ptr     = free_head_ff;
      take          = 1'b0;
      head_ptr      = NIL;
      rec_rd_en     = 1'b0;
      rec_rd_idx    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LINK;
            end
         end
         ST_LINK: begin
            ok_in = 1'b0;
            case (kind_ff)
               KIND_PUSH: begin
                  if (free_head_ff < NIL) begin
                     ok_in        = 1'b1;
                     take         = 1'b1;
                     free_head_in = lk_next;
                     lk_wr_en     = 1'b1;
                     lk_wr_idx    = free_head_ff[IW-1:0];
                     lk_wr_ptr    = stack_top_ff;
                     stack_top_in = free_head_ff;
                  end
               end
               KIND_POP: begin
                  if (stack_top_ff < NIL) begin
                     ok_in        = 1'b1;
                     stack_top_in = lk_next;
                     lk_wr_en     = 1'b1;
                     lk_wr_idx    = stack_top_ff[IW-1:0];
                     free_head_in = stack_top_ff;
                  end
               end
               KIND_ENQ: begin
                  if (free_head_ff < NIL) begin
                     ok_in        = 1'b1;
                     take         = 1'b1;
                     free_head_in = lk_next;
                     if (queue_tail_ff < NIL) begin
                        lk_wr_en  = 1'b1;
                        lk_wr_idx = queue_tail_ff[IW-1:0];
                     end else begin
                        queue_head_in = free_head_ff;
                     end
                     queue_tail_in = free_head_ff;
                  end
               end
               KIND_DEQ: begin
                  if (queue_head_ff < NIL) begin
                     ok_in = 1'b1;
                     if (queue_head_ff == queue_tail_ff) begin
                        queue_head_in = NIL;
                        queue_tail_in = NIL;
                     end else begin
                        queue_head_in = lk_next;
                     end
                     lk_wr_en     = 1'b1;
                     lk_wr_idx    = queue_head_ff[IW-1:0];
                     free_head_in = queue_head_ff;
                  end
               end
               default: begin
                  ok_in = 1'b0;
               end
            endcase
            head_ptr = ((kind_ff == KIND_PUSH) || (kind_ff == KIND_POP))
                       ? stack_top_in : queue_head_in;
            hlive_in  = head_ptr < NIL;
            fwd_in    = take && (head_ptr == free_head_ff);
            rec_rd_en = 1'b1;
            if (head_ptr < NIL) begin
               rec_rd_idx = head_ptr[IW-1:0];
            end
            state_in = ST_HEAD;
         end
         ST_HEAD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_se_in    = !(stack_top_ff < NIL);
               rsp_qe_in    = !(queue_head_ff < NIL);
               rsp_pf_in    = !(free_head_ff < NIL);
               rsp_hv_in    = hlive_ff;
               if (!hlive_ff) begin
                  rsp_rec_in = '0;
               end else if (fwd_ff) begin
                  rsp_rec_in = rec_ff;
               end else begin
                  rsp_rec_in = rec_q;
               end
               state_in = accept ? ST_LINK : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (accept) begin
         kind_in      = kind_type'(req_kind);
         rec_in.id    = req_prod_id;
         rec_in.qty   = req_quantity;
         rec_in.price = req_price_cents;
         rec_in.day   = req_exp_day;
         rec_in.month = req_exp_month;
         rec_in.year  = req_exp_year;
         lk_rd_en     = 1'b1;
         case (kind_type'(req_kind))
            KIND_PUSH: rd_ptr = free_head_ff;
            KIND_POP:  rd_ptr = stack_top_ff;
            KIND_ENQ:  rd_ptr = free_head_ff;
            KIND_DEQ:  rd_ptr = queue_head_ff;
            default:   rd_ptr = free_head_ff;
         endcase
      end
   end

   assign lk_rd_idx = (rd_ptr < NIL) ? rd_ptr[IW-1:0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         free_head_ff  <= '0;
         stack_top_ff  <= NIL;
         queue_head_ff <= NIL;
         queue_tail_ff <= NIL;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_head_ff  <= free_head_in;
         stack_top_ff  <= stack_top_in;
         queue_head_ff <= queue_head_in;
         queue_tail_ff <= queue_tail_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      rec_ff     <= rec_in;
      ok_ff      <= ok_in;
      hlive_ff   <= hlive_in;
      fwd_ff     <= fwd_in;
      rsp_ok_ff  <= rsp_ok_in;
      rsp_se_ff  <= rsp_se_in;
      rsp_qe_ff  <= rsp_qe_in;
      rsp_pf_ff  <= rsp_pf_in;
      rsp_hv_ff  <= rsp_hv_in;
      rsp_rec_ff <= rsp_rec_in;
   end

   spsq_next_ram #(
      .POOL_SIZE (POOL_SIZE),
      .IW        (IW)
   ) u_next_ram (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (lk_rd_en),
      .rd_idx    (lk_rd_idx),
      .rd_next   (lk_next),
      .wr_en     (lk_wr_en),
      .wr_idx    (lk_wr_idx),
      .wr_ptr    (lk_wr_ptr),
      .claim_en  (take),
      .claim_idx (free_head_ff[IW-1:0])
   );

   spsq_rec_ram #(
      .POOL_SIZE (POOL_SIZE),
      .IW        (IW)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (take),
      .wr_idx  (free_head_ff[IW-1:0]),
      .wr_data (rec_ff),
      .rd_en   (rec_rd_en),
      .rd_idx  (rec_rd_idx),
      .rd_data (rec_q)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_stack_empty = rsp_se_ff;
   assign rsp_queue_empty = rsp_qe_ff;
   assign rsp_pool_full   = rsp_pf_ff;
   assign rsp_head_valid  = rsp_hv_ff;
   assign rsp_head_id     = rsp_rec_ff.id;
   assign rsp_head_qty    = rsp_rec_ff.qty;
   assign rsp_head_price  = rsp_rec_ff.price;
   assign rsp_head_day    = rsp_rec_ff.day;
   assign rsp_head_month  = rsp_rec_ff.month;
   assign rsp_head_year   = rsp_rec_ff.year;

`ifndef SYNTHESIS
   a_queue_ends : assert property (@(posedge clock) disable iff (reset)
      (queue_head_ff == NIL) == (queue_tail_ff == NIL))
      else $error("queue head and tail disagree on empty");

   a_accept_link : assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_LINK))
      else $error("accepted word did not enter link update");

   a_fail_full : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_HEAD) && !ok_ff && ((kind_ff == KIND_PUSH) || (kind_ff == KIND_ENQ)))
      |-> (free_head_ff == NIL))
      else $error("take failed with free nodes left");

   a_disjoint : assert property (@(posedge clock) disable iff (reset)
      ((stack_top_ff < NIL) && (queue_head_ff < NIL)) |-> (stack_top_ff != queue_head_ff))
      else $error("stack and queue share a head node");
`endif

endmodule

FILE: dv/tb_shared_pool_stack_queue_top.sv
`timescale 1ns / 1ps

module tb_shared_pool_stack_queue_top;
   import spsq_pkg::*;

   localparam int NODES = 16;
   localparam logic [4:0] NIL = 5'd16;

   typedef struct {
      kind_type kind;
      rec_type  rec;
      bit       drain;
   } order_type;

   typedef struct packed {
      logic    ok;
      logic    stack_empty;
      logic    queue_empty;
      logic    pool_full;
      logic    head_valid;
      rec_type head;
   } status_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_kind = 2'd0;
   logic [15:0] req_prod_id = 16'd0;
   logic [15:0] req_quantity = 16'd0;
   logic [23:0] req_price_cents = 24'd0;
   logic [4:0]  req_exp_day = 5'd1;
   logic [3:0]  req_exp_month = 4'd0;
   logic [13:0] req_exp_year = 14'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_ok;
   logic        rsp_stack_empty;
   logic        rsp_queue_empty;
   logic        rsp_pool_full;
   logic        rsp_head_valid;
   logic [15:0] rsp_head_id;
   logic [15:0] rsp_head_qty;
   logic [23:0] rsp_head_price;
   logic [4:0]  rsp_head_day;
   logic [3:0]  rsp_head_month;
   logic [13:0] rsp_head_year;

   shared_pool_stack_queue_top #(.POOL_SIZE(NODES)) dut (.*);

   // pool model
   logic [4:0] free_head;
   logic [4:0] stack_top;
   logic [4:0] queue_head;
   logic [4:0] queue_tail;
   logic [4:0] node_link [NODES];
   rec_type    node_rec [NODES];

   order_type  pending_orders [$];
   status_type expected_status [$];
   order_type  offered;
   int      orders_sent = 0;
   int      status_seen = 0;
   int      mismatches = 0;
   int      burst_left = 1;
   int      gap_left = 0;
   int      rx_cycle = 0;
   int      hold_left = 0;
   int      holds_done = 0;
   int      stall_phase;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic status_type apply_order(order_type o);
      status_type r;
      logic [4:0] n;
      logic [4:0] h;
      r = '0;
      case (o.kind)
         KIND_PUSH: begin
            if (free_head < NODES) begin
               n = free_head;
               free_head = node_link[n];
               node_rec[n] = o.rec;
               node_link[n] = stack_top;
               stack_top = n;
               r.ok = 1'b1;
            end
         end
         KIND_POP: begin
            if (stack_top < NODES) begin
               n = stack_top;
               stack_top = node_link[n];
               node_link[n] = free_head;
               free_head = n;
               r.ok = 1'b1;
            end
         end
         KIND_ENQ: begin
            if (free_head < NODES) begin
               n = free_head;
               free_head = node_link[n];
               node_rec[n] = o.rec;
               node_link[n] = NIL;
               if (queue_tail < NODES) node_link[queue_tail] = n;
               else queue_head = n;
               queue_tail = n;
               r.ok = 1'b1;
            end
         end
         default: begin
            if (queue_head < NODES) begin
               n = queue_head;
               queue_head = node_link[n];
               if (!(queue_head < NODES)) begin
                  queue_head = NIL;
                  queue_tail = NIL;
               end
               node_link[n] = free_head;
               free_head = n;
               r.ok = 1'b1;
            end
         end
      endcase
      h = (o.kind == KIND_PUSH || o.kind == KIND_POP) ? stack_top : queue_head;
      r.stack_empty = !(stack_top < NODES);
      r.queue_empty = !(queue_head < NODES);
      r.pool_full = !(free_head < NODES);
      if (h < NODES) begin
         r.head_valid = 1'b1;
         r.head = node_rec[h];
      end
      return r;
   endfunction

   function automatic rec_type random_record();
      rec_type r;
      r.id = 16'($urandom);
      r.qty = 16'($urandom);
      r.price = 24'($urandom);
      r.day = 5'($urandom_range(1, 31));
      r.month = 4'($urandom);
      r.year = 14'($urandom_range(0, 9999));
      return r;
   endfunction

   function automatic order_type make_order(kind_type k, rec_type r, bit drain);
      order_type o;
      o.kind = k;
      o.rec = r;
      o.drain = drain;
      return o;
   endfunction

   function automatic kind_type pick_kind(int fill_pct, int lanes);
      logic ins;
      logic on_stack;
      ins = $urandom_range(0, 99) < fill_pct;
      on_stack = (lanes == 1) ? 1'b1 : (lanes == 2) ? 1'b0 : 1'($urandom_range(0, 1));
      if (ins) return on_stack ? KIND_PUSH : KIND_ENQ;
      return on_stack ? KIND_POP : KIND_DEQ;
   endfunction

   task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
      mismatches++;
      if (mismatches <= 40)
         $display("%0t: %s: got %0h, want %0h", $realtime, what, got, want);
   endtask

   initial begin : stimulus
      rec_type hi_rec;
      rec_type lo_rec;
      rec_type m12_rec;
      int      i;
      int      fill_pct;
      int      lanes;

      free_head = 5'd0;
      stack_top = NIL;
      queue_head = NIL;
      queue_tail = NIL;
      for (i = 0; i < NODES; i++) node_link[i] = 5'(i + 1);

      hi_rec = '{year: 14'd9999, month: 4'd15, day: 5'd31, price: 24'hFFFFFF,
                 qty: 16'hFFFF, id: 16'hFFFF};
      lo_rec = '{year: 14'd0, month: 4'd0, day: 5'd1, price: 24'd0, qty: 16'd0, id: 16'd0};
      m12_rec = random_record();
      m12_rec.month = 4'd12;

      pending_orders.push_back(make_order(KIND_POP, random_record(), 1'b0));
      pending_orders.push_back(make_order(KIND_DEQ, random_record(), 1'b0));
      pending_orders.push_back(make_order(KIND_ENQ, hi_rec, 1'b0));
      pending_orders.push_back(make_order(KIND_ENQ, lo_rec, 1'b0));
      pending_orders.push_back(make_order(KIND_PUSH, lo_rec, 1'b0));
      pending_orders.push_back(make_order(KIND_PUSH, m12_rec, 1'b0));
      pending_orders.push_back(make_order(KIND_PUSH, hi_rec, 1'b0));
      pending_orders.push_back(make_order(KIND_DEQ, random_record(), 1'b0));
      pending_orders.push_back(make_order(KIND_DEQ, random_record(), 1'b0));
      pending_orders.push_back(make_order(KIND_ENQ, random_record(), 1'b0));
      pending_orders.push_back(make_order(KIND_DEQ, random_record(), 1'b0));
      // fill the pool, then overflow on both sides
      for (i = 0; i < 13; i++)
         pending_orders.push_back(make_order((i % 2) ? KIND_ENQ : KIND_PUSH,
                                             random_record(), 1'b0));
      pending_orders.push_back(make_order(KIND_PUSH, random_record(), 1'b0));
      pending_orders.push_back(make_order(KIND_ENQ, random_record(), 1'b0));
      pending_orders.push_back(make_order(KIND_POP, random_record(), 1'b1));

      fill_pct = 50;
      lanes = 0;
      for (i = 0; i < 950; i++) begin
         if (i % 40 == 0) begin
            case ($urandom_range(0, 2))
               0: fill_pct = 20;
               1: fill_pct = 50;
               default: fill_pct = 80;
            endcase
            lanes = $urandom_range(0, 3);
         end
         pending_orders.push_back(make_order(pick_kind(fill_pct, lanes), random_record(),
                                             (i % 320) == 319));
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_orders.size() != 0 || req_valid) @(posedge clock);
      while (status_seen != orders_sent) @(posedge clock);
      repeat (12) @(posedge clock);
      if (expected_status.size() != 0)
         report_mismatch("words never returned", 24'(expected_status.size()), 24'd0);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

   always @(posedge clock) begin : source
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_status.push_back(apply_order(offered));
            orders_sent++;
         end
         // hold a stalled word
         if (!(req_valid && req_stall)) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_orders.size() == 0) begin
               req_valid <= 1'b0;
            end else if (pending_orders[0].drain) begin
               if (status_seen == orders_sent) pending_orders.delete(0);
               req_valid <= 1'b0;
            end else begin
               offered = pending_orders.pop_front();
               req_valid <= 1'b1;
               req_kind <= offered.kind;
               req_prod_id <= offered.rec.id;
               req_quantity <= offered.rec.qty;
               req_price_cents <= offered.rec.price;
               req_exp_day <= offered.rec.day;
               req_exp_month <= offered.rec.month;
               req_exp_year <= offered.rec.year;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 30);
                  gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 5);
               end
            end
         end
      end
   end

   always @(posedge clock) begin : sink
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rx_cycle++;
         if (hold_left == 0 && holds_done < 2 && status_seen >= 200 + 500 * holds_done) begin
            hold_left = 300;
            holds_done++;
         end
         stall_phase = (rx_cycle / 97) % 4;
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= (stall_phase == 1) ? 1'($urandom_range(0, 1)) :
                         (stall_phase == 2) ? (rx_cycle % 4 != 0) :
                         (stall_phase == 3) ? ($urandom_range(0, 3) == 0) : 1'b0;
         end
      end
   end

   always @(posedge clock) begin : watch
      status_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         status_seen <= status_seen + 1;
         if (expected_status.size() == 0) begin
            report_mismatch("unexpected word", 24'd1, 24'd0);
         end else begin
            want = expected_status.pop_front();
            if (rsp_ok !== want.ok) report_mismatch("ok", rsp_ok, want.ok);
            if (rsp_stack_empty !== want.stack_empty)
               report_mismatch("stack_empty", rsp_stack_empty, want.stack_empty);
            if (rsp_queue_empty !== want.queue_empty)
               report_mismatch("queue_empty", rsp_queue_empty, want.queue_empty);
            if (rsp_pool_full !== want.pool_full)
               report_mismatch("pool_full", rsp_pool_full, want.pool_full);
            if (rsp_head_valid !== want.head_valid)
               report_mismatch("head_valid", rsp_head_valid, want.head_valid);
            if (rsp_head_id !== want.head.id)
               report_mismatch("head_id", rsp_head_id, want.head.id);
            if (rsp_head_qty !== want.head.qty)
               report_mismatch("head_qty", rsp_head_qty, want.head.qty);
            if (rsp_head_price !== want.head.price)
               report_mismatch("head_price", rsp_head_price, want.head.price);
            if (rsp_head_day !== want.head.day)
               report_mismatch("head_day", rsp_head_day, want.head.day);
            if (rsp_head_month !== want.head.month)
               report_mismatch("head_month", rsp_head_month, want.head.month);
            if (rsp_head_year !== want.head.year)
               report_mismatch("head_year", rsp_head_year, want.head.year);
         end
      end
   end

endmodule
